[sv/point_segment_distance_top_defines.svh]
// Assertion macros shared by the point to segment distance RTL.
// Used by the queue and back-end modules; no other dependencies.
`ifndef POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSD_ASSERT(lbl, prop, msg)
`define PSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/psd_pkg.sv]
// Types, constants and step functions for the point to segment distance block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int DIV_STEPS = 16;
  localparam int SQ_STEPS = 17;
  localparam logic [16:0] T_ONE = 17'h10000;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] qx;
    logic signed [16:0] qy;
    logic [33:0]        a;
    logic [34:0]        nb;
    cls_t               cls;
  } fq_t;

  typedef struct packed {
    logic               valid;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] qx;
    logic signed [16:0] qy;
    logic [33:0]        a;
    logic [34:0]        r;
    logic [15:0]        q;
    cls_t               cls;
  } dv_t;

  typedef struct packed {
    logic        valid;
    logic [33:0] n;
    logic [19:0] rem;
    logic [16:0] root;
    logic [16:0] t;
  } sq_t;

  function automatic dv_t div_step(dv_t s);
    dv_t o;
    logic [35:0] r2;
    o = s;
    r2 = {s.r, 1'b0};
    if (r2 >= {2'b00, s.a}) begin
      o.r = 35'(r2 - {2'b00, s.a});
      o.q = {s.q[14:0], 1'b1};
    end else begin
      o.r = r2[34:0];
      o.q = {s.q[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t o;
    logic [21:0] cur;
    logic [21:0] trial;
    o = s;
    cur = {s.rem, s.n[33:32]};
    trial = {3'b000, s.root, 2'b01};
    if (cur >= trial) begin
      o.rem = 20'(cur - trial);
      o.root = {s.root[15:0], 1'b1};
    end else begin
      o.rem = cur[19:0];
      o.root = {s.root[15:0], 1'b0};
    end
    o.n = {s.n[31:0], 2'b00};
    return o;
  endfunction

endpackage
`default_nettype wire

[sv/psd_front.sv]
// Front end: takes queries, forms the segment terms and classifies the projection.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  output logic                    fq_valid,
  input  wire logic               fq_stall,
  output psd_pkg::fq_t            fq_data
);
  import psd_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [16:0] dx1_r, dy1_r, qx1_r, qy1_r;
  logic signed [16:0] dx2_r, dy2_r, qx2_r, qy2_r;
  logic signed [33:0] pxx_r, pyy_r, pbx_r, pby_r;
  logic signed [16:0] dx3_r, dy3_r, qx3_r, qy3_r;
  logic [33:0] a3_r;
  logic [34:0] nb3_r;
  fq_t out_r;
  cls_t cls_nxt;

  assign en = !(v4_r && fq_stall);
  assign in_stall = !en;

  always_comb begin
    priority if (a3_r == '0 || nb3_r[34] || nb3_r == '0) begin
      cls_nxt = CLS_ZERO;
    end else if ($signed(nb3_r) >= $signed({1'b0, a3_r})) begin
      cls_nxt = CLS_ONE;
    end else begin
      cls_nxt = CLS_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= {in_end_x[15], in_end_x} - {in_start_x[15], in_start_x};
      dy1_r <= {in_end_y[15], in_end_y} - {in_start_y[15], in_start_y};
      qx1_r <= {in_point_x[15], in_point_x} - {in_start_x[15], in_start_x};
      qy1_r <= {in_point_y[15], in_point_y} - {in_start_y[15], in_start_y};
      pxx_r <= dx1_r * dx1_r;
      pyy_r <= dy1_r * dy1_r;
      pbx_r <= dx1_r * qx1_r;
      pby_r <= dy1_r * qy1_r;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      qx2_r <= qx1_r;
      qy2_r <= qy1_r;
      a3_r <= 34'(pxx_r + pyy_r);
      nb3_r <= {pbx_r[33], pbx_r} + {pby_r[33], pby_r};
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      qx3_r <= qx2_r;
      qy3_r <= qy2_r;
      out_r.dx <= dx3_r;
      out_r.dy <= dy3_r;
      out_r.qx <= qx3_r;
      out_r.qy <= qy3_r;
      out_r.a <= a3_r;
      out_r.nb <= nb3_r;
      out_r.cls <= cls_nxt;
    end
  end

  assign fq_valid = v4_r;
  assign fq_data = out_r;
endmodule
`default_nettype wire

[sv/psd_queue.sv]
// Short queue between front and back ends.
// Depends on psd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_distance_top_defines.svh"
module psd_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_stall,
  input  wire psd_pkg::fq_t push_data,
  output logic              pop_valid,
  input  wire logic         pop_stall,
  output psd_pkg::fq_t      pop_data
);
  import psd_pkg::*;

  fq_t mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0] cnt_r;
  logic push, pop;

  assign push_stall = (cnt_r == QAW'(0) + (QAW+1)'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push = push_valid && !push_stall;
  assign pop = pop_valid && !pop_stall;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  `PSD_ASSERT(a_cnt_bound, cnt_r <= (QAW+1)'(QDEPTH), "queue count above depth")
  `PSD_ASSERT(a_cnt_track, $past(push) && !$past(pop) |-> cnt_r == $past(cnt_r) + 1'b1,
    "queue count missed a push")
  `PSD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> cnt_r == '0, "queue not empty after reset")
endmodule
`default_nettype wire

[sv/psd_back.sv]
// Back end: divider for the projection parameter, nearest point offsets and square root.
// Depends on psd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_distance_top_defines.svh"
module psd_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fq_valid,
  output logic              fq_stall,
  input  wire psd_pkg::fq_t fq_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [16:0]       out_distance,
  output logic [16:0]       out_segment_param
);
  import psd_pkg::*;

  logic en;
  dv_t div_r [DIV_STEPS+1];
  sq_t sq_r [SQ_STEPS+1];
  dv_t last;

  logic m1_v_r, m2_v_r, m3_v_r;
  logic signed [16:0] m1_qx_r, m1_qy_r;
  logic signed [34:0] m1_px_r, m1_py_r;
  logic [16:0] m1_t_r, m2_t_r, m3_t_r;
  logic [31:0] m2_mx_r, m2_my_r;
  logic [63:0] m3_sx_r, m3_sy_r;

  logic [16:0] t_nxt;
  logic signed [35:0] ddx, ddy;
  logic [35:0] adx, ady;
  logic [64:0] sum;

  assign en = !(sq_r[SQ_STEPS].valid && out_stall);
  assign fq_stall = !en;
  assign last = div_r[DIV_STEPS];

  always_comb begin
    unique case (last.cls)
      CLS_ONE:  t_nxt = T_ONE;
      CLS_DIV:  t_nxt = {1'b0, last.q};
      default:  t_nxt = '0;
    endcase
  end

  assign ddx = {{3{m1_qx_r[16]}}, m1_qx_r, 16'h0000} - {m1_px_r[34], m1_px_r};
  assign ddy = {{3{m1_qy_r[16]}}, m1_qy_r, 16'h0000} - {m1_py_r[34], m1_py_r};
  assign adx = ddx[35] ? 36'(-ddx) : 36'(ddx);
  assign ady = ddy[35] ? 36'(-ddy) : 36'(ddy);
  assign sum = {1'b0, m3_sx_r} + {1'b0, m3_sy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) div_r[k] <= '0;
      for (int k = 0; k <= SQ_STEPS; k++) sq_r[k] <= '0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
    end else if (en) begin
      div_r[0].valid <= fq_valid;
      div_r[0].dx <= fq_data.dx;
      div_r[0].dy <= fq_data.dy;
      div_r[0].qx <= fq_data.qx;
      div_r[0].qy <= fq_data.qy;
      div_r[0].a <= fq_data.a;
      div_r[0].r <= fq_data.nb;
      div_r[0].q <= '0;
      div_r[0].cls <= fq_data.cls;
      for (int k = 0; k < DIV_STEPS; k++) div_r[k+1] <= div_step(div_r[k]);
      m1_v_r <= last.valid;
      m1_qx_r <= last.qx;
      m1_qy_r <= last.qy;
      m1_px_r <= last.dx * $signed({1'b0, t_nxt});
      m1_py_r <= last.dy * $signed({1'b0, t_nxt});
      m1_t_r <= t_nxt;
      m2_v_r <= m1_v_r;
      m2_mx_r <= adx[31:0];
      m2_my_r <= ady[31:0];
      m2_t_r <= m1_t_r;
      m3_v_r <= m2_v_r;
      m3_sx_r <= m2_mx_r * m2_mx_r;
      m3_sy_r <= m2_my_r * m2_my_r;
      m3_t_r <= m2_t_r;
      sq_r[0].valid <= m3_v_r;
      sq_r[0].n <= {1'b0, sum[64:32]};
      sq_r[0].rem <= '0;
      sq_r[0].root <= '0;
      sq_r[0].t <= m3_t_r;
      for (int k = 0; k < SQ_STEPS; k++) sq_r[k+1] <= sq_step(sq_r[k]);
    end
  end

  assign out_valid = sq_r[SQ_STEPS].valid;
  assign out_distance = sq_r[SQ_STEPS].root;
  assign out_segment_param = sq_r[SQ_STEPS].t;

  `PSD_ASSERT(a_t_range, out_valid |-> out_segment_param <= T_ONE, "parameter out of range")
  `PSD_ASSERT(a_div_rem, last.valid && last.cls == CLS_DIV |-> last.r < {1'b0, last.a},
    "divider remainder not below divisor")
  `PSD_ASSERT(a_zero_t, m1_v_r && $past(en) && $past(last.cls) == CLS_ZERO |-> m1_t_r == '0,
    "degenerate projection gave nonzero parameter")
endmodule
`default_nettype wire

[sv/point_segment_distance_top.sv]
// Point to segment distance, one query per cycle while in_stall is low.
// With the queue empty the path is: 4 front stages, the queue, 17 divider
// stages, 4 offset and square stages and 17 square root stages.
// Unstalled, one transfer per cycle, set by the bit-per-stage divider and root.
// Synchronous active-low reset empties all stages and the queue.
`timescale 1ns / 1ps
`default_nettype none
module point_segment_distance_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             out_distance,
  output logic [16:0]             out_segment_param
);
  import psd_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  fq_t f_data, b_data;

  psd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_point_x, .in_point_y, .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .fq_valid(f_valid), .fq_stall(f_stall), .fq_data(f_data)
  );

  psd_queue u_queue (
    .clk, .rst_n,
    .push_valid(f_valid), .push_stall(f_stall), .push_data(f_data),
    .pop_valid(b_valid), .pop_stall(b_stall), .pop_data(b_data)
  );

  psd_back u_back (
    .clk, .rst_n,
    .fq_valid(b_valid), .fq_stall(b_stall), .fq_data(b_data),
    .out_valid, .out_stall, .out_distance, .out_segment_param
  );
endmodule
`default_nettype wire
